/* rtl/glyph_text_blitter_8x8_defines.svh */
// ----------------------------------------------------------------------------
// glyph_text_blitter_8x8_defines
// Assertion macros used by the text blitter top level. The macros expand to
// nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_BLITTER_8X8_DEFINES_SVH
`define GLYPH_TEXT_BLITTER_8X8_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define GTB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gtb assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define GTB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gtb assertion failed");
`else
`define GTB_ASSERT_IMP(lbl, ante, cons)
`define GTB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/gtb_pkg.sv */
// ----------------------------------------------------------------------------
// gtb_pkg
// Constants, types and control structs of the 8x8 glyph text blitter.
// ----------------------------------------------------------------------------
package gtb_pkg;

	// screen and font geometry
	localparam int SCREEN_WIDTH  = 400;
	localparam int GLYPH_COUNT   = 256;
	localparam int COLUMN_STRIDE = 720;

	localparam int GLYPH_DEPTH = GLYPH_COUNT * 8;
	localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);

	typedef logic [GLYPH_AW-1:0] glyph_addr_t;
	typedef logic [31:0]         addr_t;
	typedef logic [9:0]          cursor_t;
	typedef logic [5:0]          line_t;
	typedef logic [10:0]         wrap_sum_t;

	localparam line_t     LINE_MAX    = 6'd63;
	localparam cursor_t   CURSOR_STEP = 10'd8;
	localparam wrap_sum_t WRAP_LIMIT  = wrap_sum_t'(SCREEN_WIDTH);

	// address steps: next column, and from column 7 back to column 0 of the next row
	localparam addr_t STRIDE_STEP = addr_t'(COLUMN_STRIDE);
	localparam addr_t ROW_STEP    = addr_t'(0) - addr_t'(7 * COLUMN_STRIDE + 3);

	// shared adder operations
	typedef logic [1:0] alu_op_t;
	localparam alu_op_t ALU_BASE_PROD  = 2'd0;
	localparam alu_op_t ALU_ADD_STRIDE = 2'd1;
	localparam alu_op_t ALU_ADD_NEGY   = 2'd2;
	localparam alu_op_t ALU_ADD_ROW    = 2'd3;

	typedef struct packed {
		logic    en;
		alu_op_t op;
	} alu_ctl_t;

	typedef struct packed {
		addr_t base;
		addr_t prod;
		addr_t neg_y;
	} alu_opnd_t;

	typedef struct packed {
		logic        we;
		glyph_addr_t waddr;
		logic [7:0]  wdata;
		logic        re;
		glyph_addr_t raddr;
	} ram_req_t;

endpackage

/* rtl/gtb_ram.sv */
// ----------------------------------------------------------------------------
// gtb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/gtb_alu.sv */
// ----------------------------------------------------------------------------
// gtb_alu
// Shared 32-bit address adder with its accumulator. Builds the first pixel
// address in three steps, then walks the glyph cell column by column.
// ----------------------------------------------------------------------------
module gtb_alu (
	input  logic              clk,
	input  gtb_pkg::alu_ctl_t ctl,
	input  gtb_pkg::alu_opnd_t opnd,
	output gtb_pkg::addr_t    acc
);

	gtb_pkg::addr_t acc_q;
	gtb_pkg::addr_t opa;
	gtb_pkg::addr_t opb;

	// operand select
	always_comb begin
		opa = acc_q;
		opb = gtb_pkg::STRIDE_STEP;
		case (ctl.op)
			gtb_pkg::ALU_BASE_PROD: begin
				opa = opnd.base;
				opb = opnd.prod;
			end
			gtb_pkg::ALU_ADD_STRIDE: opb = gtb_pkg::STRIDE_STEP;
			gtb_pkg::ALU_ADD_NEGY:   opb = opnd.neg_y;
			gtb_pkg::ALU_ADD_ROW:    opb = gtb_pkg::ROW_STEP;
			default:                 opb = gtb_pkg::STRIDE_STEP;
		endcase
	end

	// accumulator, wraps modulo 2^32
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= opa + opb;
		end
	end

	assign acc = acc_q;

endmodule

/* rtl/gtb_seq.sv */
// ----------------------------------------------------------------------------
// gtb_seq
// Sequencer of the text blitter: takes words, keeps cursor and line count,
// drives the shared adder and glyph reads, scans glyph bits and holds the
// output pixel register.
// ----------------------------------------------------------------------------
module gtb_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic                mode,
	input  logic [7:0]          char_code,
	input  logic [2:0]          glyph_row,
	input  logic [7:0]          row_bits,
	input  logic                first_of_word,
	input  logic [8:0]          start_x,
	input  logic [7:0]          start_y,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  logic [31:0]         frame_base,
	output gtb_pkg::ram_req_t   ram_req,
	input  logic [7:0]          ram_rdata,
	output gtb_pkg::alu_ctl_t   alu_ctl,
	output gtb_pkg::alu_opnd_t  alu_opnd,
	input  gtb_pkg::addr_t      acc,
	output logic                pixel_valid,
	input  logic                pixel_ready,
	output logic [31:0]         pixel_address,
	output logic [7:0]          out_blue,
	output logic [7:0]          out_green,
	output logic [7:0]          out_red,
	output logic                last_pixel
);

	localparam logic [2:0] ST_IDLE       = 3'd0;
	localparam logic [2:0] ST_WRAP       = 3'd1;
	localparam logic [2:0] ST_MUL        = 3'd2;
	localparam logic [2:0] ST_ADD_BASE   = 3'd3;
	localparam logic [2:0] ST_ADD_STRIDE = 3'd4;
	localparam logic [2:0] ST_SUB_Y      = 3'd5;
	localparam logic [2:0] ST_LOAD       = 3'd6;
	localparam logic [2:0] ST_SCAN       = 3'd7;

	logic [2:0]       state_q;
	gtb_pkg::cursor_t cursor_q;
	gtb_pkg::line_t   line_q;
	logic [3:0]       rd_cnt_q;
	logic [2:0]       col_q;
	logic             pv_q;

	// captured word
	logic [7:0]       code_q;
	logic             first_q;
	logic [8:0]       sx_q;
	logic [7:0]       sy_q;
	logic [7:0]       red_q;
	logic [7:0]       green_q;
	logic [7:0]       blue_q;
	gtb_pkg::addr_t   base_q;
	logic             glyph_ok_q;

	gtb_pkg::addr_t   prod_q;
	gtb_pkg::addr_t   neg_y_q;
	logic [63:0]      bits_q;

	gtb_pkg::addr_t   paddr_q;
	logic             plast_q;
	logic [7:0]       pblue_q;
	logic [7:0]       pgreen_q;
	logic [7:0]       pred_q;

	logic             accept;
	logic             code_ok;
	gtb_pkg::cursor_t cur_b;
	gtb_pkg::line_t   line_b;
	logic             wrap;
	logic [9:0]       y0;
	logic [11:0]      y3;
	logic             out_free;
	logic             advance;
	logic             load_px;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign code_ok    = ({1'b0, char_code} < 9'(gtb_pkg::GLYPH_COUNT));
	assign out_free   = !pv_q || pixel_ready;

	// glyph row write on a load word
	assign ram_req.we    = accept && !mode && code_ok;
	assign ram_req.waddr = gtb_pkg::glyph_addr_t'({char_code, glyph_row});
	assign ram_req.wdata = row_bits;
	assign ram_req.re    = (state_q == ST_LOAD) && !rd_cnt_q[3];
	assign ram_req.raddr = gtb_pkg::glyph_addr_t'({code_q, rd_cnt_q[2:0]});

	// wrap decision
	always_comb begin
		cur_b  = first_q ? gtb_pkg::cursor_t'(sx_q) : cursor_q;
		line_b = first_q ? '0 : line_q;
		wrap   = ({1'b0, cur_b} + 11'd8) > gtb_pkg::WRAP_LIMIT;
	end

	// top row of the text line, times three
	assign y0 = {2'b00, sy_q} + {1'b0, line_q, 3'b000};
	assign y3 = {1'b0, y0, 1'b0} + {2'b00, y0};

	// adder control and scan step
	always_comb begin
		alu_ctl.en = 1'b0;
		alu_ctl.op = gtb_pkg::ALU_ADD_STRIDE;
		advance    = 1'b0;
		load_px    = 1'b0;
		case (state_q)
			ST_ADD_BASE: begin
				alu_ctl.en = 1'b1;
				alu_ctl.op = gtb_pkg::ALU_BASE_PROD;
			end
			ST_ADD_STRIDE: begin
				alu_ctl.en = 1'b1;
				alu_ctl.op = gtb_pkg::ALU_ADD_STRIDE;
			end
			ST_SUB_Y: begin
				alu_ctl.en = 1'b1;
				alu_ctl.op = gtb_pkg::ALU_ADD_NEGY;
			end
			ST_SCAN: begin
				if (bits_q != '0) begin
					load_px    = bits_q[63] && out_free;
					advance    = !bits_q[63] || out_free;
					alu_ctl.en = advance;
					alu_ctl.op = (col_q == 3'd7) ? gtb_pkg::ALU_ADD_ROW
					                             : gtb_pkg::ALU_ADD_STRIDE;
				end
			end
			default: ;
		endcase
	end

	assign alu_opnd.base  = base_q;
	assign alu_opnd.prod  = prod_q;
	assign alu_opnd.neg_y = neg_y_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cursor_q <= '0;
			line_q   <= '0;
			rd_cnt_q <= '0;
			col_q    <= '0;
			pv_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && mode) begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					if (wrap) begin
						cursor_q <= gtb_pkg::cursor_t'(sx_q);
						line_q   <= (line_b < gtb_pkg::LINE_MAX) ? line_b + 6'd1 : line_b;
					end else begin
						cursor_q <= cur_b;
						line_q   <= line_b;
					end
					state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ADD_BASE;
				ST_ADD_BASE: begin
					cursor_q <= cursor_q + gtb_pkg::CURSOR_STEP;
					state_q  <= ST_ADD_STRIDE;
				end
				ST_ADD_STRIDE: state_q <= ST_SUB_Y;
				ST_SUB_Y: begin
					rd_cnt_q <= '0;
					state_q  <= glyph_ok_q ? ST_LOAD : ST_IDLE;
				end
				ST_LOAD: begin
					rd_cnt_q <= rd_cnt_q + 4'd1;
					if (rd_cnt_q[3]) begin
						col_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						col_q <= col_q + 3'd1;
					end
					if (bits_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// output pixel register
			if (load_px) begin
				pv_q <= 1'b1;
			end else if (pixel_ready) begin
				pv_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q     <= char_code;
			first_q    <= first_of_word;
			sx_q       <= start_x;
			sy_q       <= start_y;
			red_q      <= red;
			green_q    <= green;
			blue_q     <= blue;
			base_q     <= frame_base;
			glyph_ok_q <= code_ok;
		end
		if (state_q == ST_MUL) begin
			prod_q  <= gtb_pkg::addr_t'(cursor_q) * gtb_pkg::STRIDE_STEP;
			neg_y_q <= gtb_pkg::addr_t'(0) - gtb_pkg::addr_t'(y3);
		end
		// glyph rows arrive in the cycle after their read
		if ((state_q == ST_LOAD) && (rd_cnt_q != 4'd0)) begin
			bits_q <= {bits_q[55:0], ram_rdata};
		end else if (advance) begin
			bits_q <= {bits_q[62:0], 1'b0};
		end
		// colour travels with the pixel, so a new word cannot disturb a waiting one
		if (load_px) begin
			paddr_q  <= acc;
			plast_q  <= (bits_q[62:0] == '0);
			pblue_q  <= blue_q;
			pgreen_q <= green_q;
			pred_q   <= red_q;
		end
	end

	assign pixel_valid   = pv_q;
	assign pixel_address = paddr_q;
	assign out_blue      = pblue_q;
	assign out_green     = pgreen_q;
	assign out_red       = pred_q;
	assign last_pixel    = plast_q;

endmodule

/* rtl/glyph_text_blitter_8x8.sv */
// ----------------------------------------------------------------------------
// glyph_text_blitter_8x8
// 8x8 bitmap font text blitter for a column-major 24-bit framebuffer.
// ----------------------------------------------------------------------------
// A load word (mode 0) writes one glyph row as it is taken; the next word
// may follow at once. A draw word (mode 1) applies the word start and line
// wrap, then builds the first pixel address with a constant multiply and
// three passes through one shared 32-bit adder, reads the eight glyph rows
// from the glyph RAM through its single registered read port and scans the
// cell one glyph bit per cycle, stopping after the last set bit and returning
// to idle; a set bit waits while an earlier pixel still waits on pixel_ready.
// item_ready is low for the whole draw. The last pixel of a character may
// still wait in the output register while the next word is taken; its
// address and colour bytes are held with it. The glyph RAM has no reset;
// rows must be loaded before they are drawn.
module glyph_text_blitter_8x8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        mode,
	input  logic [7:0]  char_code,
	input  logic [2:0]  glyph_row,
	input  logic [7:0]  row_bits,
	input  logic        first_of_word,
	input  logic [8:0]  start_x,
	input  logic [7:0]  start_y,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [31:0] frame_base,
	output logic        pixel_valid,
	input  logic        pixel_ready,
	output logic [31:0] pixel_address,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_green,
	output logic [7:0]  out_red,
	output logic        last_pixel
);

`include "glyph_text_blitter_8x8_defines.svh"

	gtb_pkg::ram_req_t  ram_req;
	logic [7:0]         ram_rdata;
	gtb_pkg::alu_ctl_t  alu_ctl;
	gtb_pkg::alu_opnd_t alu_opnd;
	gtb_pkg::addr_t     acc;

	// glyph store
	gtb_ram #(
		.WIDTH(8),
		.DEPTH(gtb_pkg::GLYPH_DEPTH)
	) u_glyph_ram (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re   (ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	// shared address adder
	gtb_alu u_alu (
		.clk (clk),
		.ctl (alu_ctl),
		.opnd(alu_opnd),
		.acc (acc)
	);

	// sequencer
	gtb_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.mode         (mode),
		.char_code    (char_code),
		.glyph_row    (glyph_row),
		.row_bits     (row_bits),
		.first_of_word(first_of_word),
		.start_x      (start_x),
		.start_y      (start_y),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.frame_base   (frame_base),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata),
		.alu_ctl      (alu_ctl),
		.alu_opnd     (alu_opnd),
		.acc          (acc),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel_address(pixel_address),
		.out_blue     (out_blue),
		.out_green    (out_green),
		.out_red      (out_red),
		.last_pixel   (last_pixel)
	);

	// a draw word blocks the input in the next cycle
	`GTB_ASSERT_NEXT(a_draw_blocks, item_valid && item_ready && mode, !item_ready)
	// a pixel that is not the last one means the character is still in work
	`GTB_ASSERT_IMP(a_mid_char_busy, pixel_valid && !last_pixel, !item_ready)
	// a new pixel is only produced while a character is being scanned
	`GTB_ASSERT_IMP(a_pixel_in_scan, $rose(pixel_valid), !item_ready)

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the 8x8 glyph text blitter against a cycle-free model of its text
// cursor, line wrap and glyph store. Words are queued up front and offered by
// a falling-edge driver; every accepted draw word predicts its pixel words,
// which are compared field by field as they leave the block.
// ----------------------------------------------------------------------------
module testbench;

	// one input word, fields in port order
	typedef struct packed {
		logic           mode;
		logic [7:0]     char_code;
		logic [2:0]     glyph_row;
		logic [7:0]     row_bits;
		logic           first_of_word;
		logic [8:0]     start_x;
		logic [7:0]     start_y;
		logic [7:0]     red;
		logic [7:0]     green;
		logic [7:0]     blue;
		gtb_pkg::addr_t frame_base;
	} word_t;

	// one pixel word
	typedef struct packed {
		gtb_pkg::addr_t address;
		logic [7:0]     blue;
		logic [7:0]     green;
		logic [7:0]     red;
		logic           last;
	} pixel_t;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_DRAW = 1'b1;

	localparam int IDLE_PCT    = 12;
	localparam int HOLD_START  = 1500;
	localparam int HOLD_LEN    = 400;
	localparam int QUIET_FROM  = 4000;
	localparam int QUIET_TO    = 6500;
	localparam int DRAIN_WAIT  = 200;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TARGET      = 180;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic           item_valid  = 1'b0;
	logic           item_ready;
	word_t          offered     = '0;
	logic           pixel_valid;
	logic           pixel_ready = 1'b0;
	gtb_pkg::addr_t pixel_address;
	logic [7:0]     out_blue;
	logic [7:0]     out_green;
	logic [7:0]     out_red;
	logic           last_pixel;

	// stimulus and expectation stores
	word_t  word_q[$];
	pixel_t pixel_q[$];

	// font and cursor state as the block should hold it
	logic [7:0]       glyph_mem [gtb_pkg::GLYPH_DEPTH];
	gtb_pkg::cursor_t cursor;
	gtb_pkg::line_t   text_line;

	// generator bookkeeping: which glyph rows have been loaded so far
	logic [7:0] rows_loaded [gtb_pkg::GLYPH_COUNT];
	logic [7:0] drawable[$];

	int cycle_no       = 0;
	int words_offered  = 0;
	int words_taken    = 0;
	int total_words    = 0;
	int loads_taken    = 0;
	int draws_taken    = 0;
	int pixels_checked = 0;
	int errors         = 0;
	int hold_left      = 0;
	bit hold_done      = 1'b0;

	wire quiet = (cycle_no >= QUIET_FROM) && (cycle_no < QUIET_TO);

	glyph_text_blitter_8x8 dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.mode         (offered.mode),
		.char_code    (offered.char_code),
		.glyph_row    (offered.glyph_row),
		.row_bits     (offered.row_bits),
		.first_of_word(offered.first_of_word),
		.start_x      (offered.start_x),
		.start_y      (offered.start_y),
		.red          (offered.red),
		.green        (offered.green),
		.blue         (offered.blue),
		.frame_base   (offered.frame_base),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel_address(pixel_address),
		.out_blue     (out_blue),
		.out_green    (out_green),
		.out_red      (out_red),
		.last_pixel   (last_pixel)
	);

	always #5 clk = ~clk;

	// font load or character draw, pushing the pixel words it should produce
	function automatic void render_word(word_t w);
		logic [7:0]     bits;
		gtb_pkg::addr_t y;
		pixel_t         p;
		int             last_pos;
		if (w.mode == MODE_LOAD) begin
			if (int'(w.char_code) < gtb_pkg::GLYPH_COUNT)
				glyph_mem[{w.char_code, w.glyph_row}] = w.row_bits;
			return;
		end
		if (w.first_of_word) begin
			cursor    = gtb_pkg::cursor_t'(w.start_x);
			text_line = '0;
		end
		// line wrap before the cell is placed
		if (int'(cursor) + 8 > gtb_pkg::SCREEN_WIDTH) begin
			if (text_line < gtb_pkg::LINE_MAX)
				text_line = text_line + 1'b1;
			cursor = gtb_pkg::cursor_t'(w.start_x);
		end
		if (int'(w.char_code) < gtb_pkg::GLYPH_COUNT) begin
			last_pos = -1;
			for (int j = 0; j < 64; j++) begin
				bits = glyph_mem[{w.char_code, 3'(j / 8)}];
				if (bits[7 - (j % 8)])
					last_pos = j;
			end
			// scan rows top down, columns msb first
			for (int j = 0; j < 64; j++) begin
				bits = glyph_mem[{w.char_code, 3'(j / 8)}];
				if (bits[7 - (j % 8)]) begin
					y = gtb_pkg::addr_t'(w.start_y)
						+ gtb_pkg::addr_t'(8) * gtb_pkg::addr_t'(text_line)
						+ gtb_pkg::addr_t'(j / 8);
					p.address = w.frame_base
						+ gtb_pkg::addr_t'(gtb_pkg::COLUMN_STRIDE)
						* (gtb_pkg::addr_t'(cursor) + gtb_pkg::addr_t'(j % 8))
						+ gtb_pkg::addr_t'(gtb_pkg::COLUMN_STRIDE)
						- gtb_pkg::addr_t'(3) * y;
					p.blue  = w.blue;
					p.green = w.green;
					p.red   = w.red;
					p.last  = (j == last_pos);
					pixel_q.push_back(p);
				end
			end
		end
		cursor = cursor + gtb_pkg::CURSOR_STEP;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
		end
	endfunction

	function automatic word_t rand_word();
		word_t       w;
		logic [95:0] rnd;
		rnd       = {$urandom, $urandom, $urandom};
		w         = rnd[$bits(word_t)-1:0];
		w.start_x = 9'($urandom_range(399));
		w.start_y = 8'($urandom_range(239));
		return w;
	endfunction

	// row patterns of varying density
	function automatic logic [7:0] pick_bits();
		case ($urandom_range(4))
			0: return 8'($urandom & $urandom);
			1: return 8'($urandom);
			2: return 8'($urandom | $urandom);
			3: return 8'h80 >> $urandom_range(7);
			default: return 8'($urandom_range(255) == 0 ? 0 : $urandom & $urandom & $urandom);
		endcase
	endfunction

	task automatic push_load(logic [7:0] code, logic [2:0] row, logic [7:0] bits);
		word_t w;
		w           = rand_word();
		w.mode      = MODE_LOAD;
		w.char_code = code;
		w.glyph_row = row;
		w.row_bits  = bits;
		word_q.push_back(w);
		if (rows_loaded[code] != 8'hFF) begin
			rows_loaded[code][row] = 1'b1;
			if (rows_loaded[code] == 8'hFF)
				drawable.push_back(code);
		end
	endtask

	// whole glyph, rows in rotated order
	task automatic load_glyph(logic [7:0] code);
		int first_row;
		first_row = $urandom_range(7);
		for (int j = 0; j < 8; j++)
			push_load(code, 3'(first_row + j), pick_bits());
	endtask

	task automatic push_draw(logic [7:0] code, logic first, logic [8:0] sx, logic [7:0] sy,
			logic [7:0] r, logic [7:0] g, logic [7:0] b, gtb_pkg::addr_t base);
		word_t w;
		w               = rand_word();
		w.mode          = MODE_DRAW;
		w.char_code     = code;
		w.first_of_word = first;
		w.start_x       = sx;
		w.start_y       = sy;
		w.red           = r;
		w.green         = g;
		w.blue          = b;
		w.frame_base    = base;
		word_q.push_back(w);
	endtask

	// stimulus, reset and end of run
	initial begin : stimulus
		int             len;
		int             spin;
		bit             cont;
		bit             long_done;
		logic [8:0]     sx;
		logic [7:0]     sy;
		logic [7:0]     r, g, b;
		gtb_pkg::addr_t base;
		long_done = 1'b0;
		cursor    = '0;
		text_line = '0;
		for (int c = 0; c < gtb_pkg::GLYPH_COUNT; c++)
			rows_loaded[c] = '0;

		// solid and blank glyphs
		for (int j = 0; j < 8; j++)
			push_load(8'hFF, 3'(j), 8'hFF);
		for (int j = 0; j < 8; j++)
			push_load(8'h00, 3'(j), 8'h00);
		// draw from the reset cursor, then a blank cell
		push_draw(8'hFF, 1'b0, 9'd0, 8'd0, 8'hFF, 8'h00, 8'hAA, 32'h0000_0000);
		push_draw(8'h00, 1'b0, 9'd0, 8'd0, 8'hFF, 8'h00, 8'hAA, 32'h0000_0000);
		// last column that fits, then a wrap onto the next line
		push_draw(8'hFF, 1'b1, 9'd392, 8'd239, 8'h00, 8'hFF, 8'h55, 32'hFFFF_FFFF);
		push_draw(8'hFF, 1'b0, 9'd392, 8'd239, 8'h00, 8'hFF, 8'h55, 32'hFFFF_FFFF);
		// start column too far right: wraps on every character
		push_draw(8'hFF, 1'b1, 9'd399, 8'd200, 8'h5A, 8'hA5, 8'hFF, 32'hFFFF_F000);
		push_draw(8'h00, 1'b0, 9'd399, 8'd200, 8'h5A, 8'hA5, 8'hFF, 32'hFFFF_F000);

		// random font
		for (int j = 0; j < 6; j++)
			load_glyph(8'($urandom));

		while (word_q.size() < TARGET) begin
			if (!long_done && word_q.size() > TARGET / 2) begin
				// long word that drives the line count into saturation
				long_done = 1'b1;
				sy   = 8'($urandom_range(239));
				base = $urandom;
				for (int j = 0; j < 72; j++)
					push_draw(drawable[$urandom_range(drawable.size() - 1)], j == 0, 9'd399,
						sy, 8'($urandom), 8'($urandom), 8'($urandom), base);
			end
			case ($urandom_range(99)) inside
				[0:7]:   load_glyph(8'($urandom));
				[8:15]:  push_load(8'($urandom), 3'($urandom), pick_bits());
				default: begin
					len  = $urandom_range(8, 1);
					cont = ($urandom_range(9) == 0);
					sx   = $urandom_range(1) ? 9'($urandom_range(399, 330))
						: 9'($urandom_range(399));
					sy   = 8'($urandom_range(239));
					r    = 8'($urandom);
					g    = 8'($urandom);
					b    = 8'($urandom);
					base = $urandom;
					for (int j = 0; j < len; j++)
						push_draw(drawable[$urandom_range(drawable.size() - 1)],
							j == 0 && !cont, sx, sy, r, g, b, base);
				end
			endcase
		end
		total_words = word_q.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_taken != total_words)
			@(posedge clk);
		spin = 0;
		while (pixel_q.size() != 0 && spin < DRAIN_LIMIT) begin
			@(posedge clk);
			spin++;
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pixel_q.size() != 0) begin
			errors++;
			$display("%0t: %0d pixel words never arrived, expected next %h, got none",
				$time, pixel_q.size(), pixel_q[0]);
		end

		$display("run covered %0d glyph row loads and %0d character draws",
			loads_taken, draws_taken);
		$display("%0d pixel words checked, %0d mismatches", pixels_checked, errors);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// word driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || words_taken == words_offered) begin
				if (word_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
					offered       <= word_q[0];
					item_valid    <= 1'b1;
					words_offered <= words_offered + 1;
					word_q.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// pixel receiver with one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			pixel_ready <= 1'b0;
		end else if (hold_left != 0) begin
			pixel_ready <= 1'b0;
			hold_left   <= hold_left - 1;
		end else if (!hold_done && cycle_no >= HOLD_START) begin
			pixel_ready <= 1'b0;
			hold_left   <= HOLD_LEN;
			hold_done   <= 1'b1;
		end else begin
			pixel_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// accept words into the model, compare pixel words
	always @(posedge clk) begin : monitor
		pixel_t want;
		if (arst_n) begin
			cycle_no <= cycle_no + 1;
			if (item_valid && item_ready) begin
				render_word(offered);
				words_taken++;
				if (offered.mode == MODE_LOAD)
					loads_taken++;
				else
					draws_taken++;
			end
			if (pixel_valid && pixel_ready) begin
				pixels_checked++;
				if (pixel_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected pixel word, expected none, got %h %h %h %h %b",
						$time, pixel_address, out_blue, out_green, out_red, last_pixel);
				end else begin
					want = pixel_q.pop_front();
					check_field("pixel_address", want.address, pixel_address);
					check_field("out_blue", 32'(want.blue), 32'(out_blue));
					check_field("out_green", 32'(want.green), 32'(out_green));
					check_field("out_red", 32'(want.red), 32'(out_red));
					check_field("last_pixel", 32'(want.last), 32'(last_pixel));
				end
			end
		end
	end

	// run limit
	initial begin
		#3000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
